// ===== design/pbcs_pkg.sv =====
// Shared types, constants and the pair test for the box collision sweep.
package pbcs_pkg;

   localparam int RESULT_LIMIT = 32;
   localparam int MASK_BITS = 32;
   localparam logic [1:0] KIND_FIXED = 2'd2;
   localparam logic [1:0] KIND_GHOST = 2'd3;

   typedef struct packed {
      logic signed [15:0] pos_x;
      logic signed [15:0] pos_y;
      logic signed [15:0] box_width;
      logic signed [15:0] box_height;
      logic signed [15:0] vel_x;
      logic signed [15:0] vel_y;
      logic signed [15:0] acc_x;
      logic signed [15:0] acc_y;
      logic [1:0]         body_kind;
      logic               is_rectangle;
   } entry_type;

   typedef struct packed {
      entry_type entry;
      logic      last_entity;
   } req_type;

   typedef struct packed {
      logic [5:0]           entity_index;
      logic                 collided;
      logic [MASK_BITS-1:0] partner_mask;
      logic                 unsupported_shape;
      logic                 last_result;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_LOAD,
      ST_FETCH,
      ST_LATCH,
      ST_ROW,
      ST_EMIT,
      ST_ERROR
   } state_type;

   function automatic logic opposed(logic signed [15:0] acc, logic signed [15:0] vel);
      return (acc < 0 && vel > 0) || (acc > 0 && vel < 0);
   endfunction

   function automatic logic span_overlap(logic signed [15:0] a0, logic signed [15:0] al,
                                         logic signed [15:0] b0, logic signed [15:0] bl);
      logic signed [16:0] lo;
      logic signed [16:0] ae;
      logic signed [16:0] be;
      logic signed [16:0] hi;
      lo = (a0 > b0) ? $signed({a0[15], a0}) : $signed({b0[15], b0});
      ae = $signed({a0[15], a0}) + $signed({al[15], al});
      be = $signed({b0[15], b0}) + $signed({bl[15], bl});
      hi = (ae < be) ? ae : be;
      return hi > lo;
   endfunction

   // The lower-indexed box goes in as a, the higher as b.
   function automatic logic pair_collides(entry_type a, entry_type b);
      logic      ra;
      logic      rb;
      logic      parting;
      logic      overlap;
      entry_type m;
      ra = (a.body_kind == KIND_FIXED) || (a.vel_x == 0 && a.vel_y == 0);
      rb = (b.body_kind == KIND_FIXED) || (b.vel_x == 0 && b.vel_y == 0);
      m = (rb && !ra) ? a : b;
      parting = (ra || rb) && (opposed(m.acc_y, m.vel_y) || opposed(m.acc_x, m.vel_x));
      overlap = (a.box_width > 0) && (a.box_height > 0) &&
                (b.box_width > 0) && (b.box_height > 0) &&
                span_overlap(a.pos_x, a.box_width, b.pos_x, b.box_width) &&
                span_overlap(a.pos_y, a.box_height, b.pos_y, b.box_height);
      return (a.body_kind != KIND_GHOST) && (b.body_kind != KIND_GHOST) &&
             !parting && overlap;
   endfunction

endpackage

// ===== design/pairwise_box_collision_sweep_core.sv =====
// Box store and all-pairs overlap sweep with one result beat per stored box, or one on a shape error.
// Loading accepts boxes back to back while idle; a box arriving at a full store is dropped.
// After the last box, each reported box i goes through fetch, latch, one read of the box
// memory per box j, and emit; only the first min(n,32) of n boxes are reported.
// A shape error in a run of two or more boxes gives a single result beat from the error state.
// Result beats appear in the cycle after their emit step; the receiver cannot stall.
// Synchronous reset empties the store and clears the error flag; memory is not cleared.
module pairwise_box_collision_sweep_core
   import pbcs_pkg::*;
#(
   parameter int MAX_ENTITIES = 32
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   output logic    rsp_strobe,
   output rsp_type rsp_data
);

   localparam int IDX_W = (MAX_ENTITIES > 1) ? $clog2(MAX_ENTITIES) : 1;
   localparam int CNT_W = $clog2(MAX_ENTITIES + 1);

   entry_type store_mem [MAX_ENTITIES];
   entry_type rd_data_ff;
   logic [IDX_W-1:0] rd_addr;
   logic we;

   state_type state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic err_ff, err_in;
   logic [IDX_W-1:0] bad_ff, bad_in;
   logic [IDX_W-1:0] n_last_ff, n_last_in;
   logic [IDX_W-1:0] res_last_ff, res_last_in;
   logic [IDX_W-1:0] i_ff, i_in;
   logic [IDX_W-1:0] jd_ff, jd_in;
   entry_type box_i_ff, box_i_in;
   logic [MASK_BITS-1:0] mask_ff, mask_in;
   logic hit_ff, hit_in;
   logic rsp_strobe_ff, rsp_strobe_in;
   rsp_type rsp_data_ff, rsp_data_in;
   logic pair_hit;

   always_ff @(posedge clock) begin
      if (we) begin
         store_mem[count_ff[IDX_W-1:0]] <= req_data.entry;
      end
      rd_data_ff <= store_mem[rd_addr];
   end

   assign pair_hit = (i_ff < jd_ff) ? pair_collides(box_i_ff, rd_data_ff)
                                    : pair_collides(rd_data_ff, box_i_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_LOAD;
         count_ff      <= '0;
         err_ff        <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         err_ff        <= err_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      bad_ff      <= bad_in;
      n_last_ff   <= n_last_in;
      res_last_ff <= res_last_in;
      i_ff        <= i_in;
      jd_ff       <= jd_in;
      box_i_ff    <= box_i_in;
      mask_ff     <= mask_in;
      hit_ff      <= hit_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_comb begin
      logic [CNT_W-1:0] count_nx;
      logic             err_nx;
      logic [IDX_W-1:0] bad_nx;
      state_in      = state_ff;
      count_in      = count_ff;
      err_in        = err_ff;
      bad_in        = bad_ff;
      n_last_in     = n_last_ff;
      res_last_in   = res_last_ff;
      i_in          = i_ff;
      jd_in         = jd_ff;
      box_i_in      = box_i_ff;
      mask_in       = mask_ff;
      hit_in        = hit_ff;
      rsp_strobe_in = 1'b0;
      rsp_data_in   = rsp_data_ff;
      rd_addr       = '0;
      we            = 1'b0;
      count_nx      = count_ff;
      err_nx        = err_ff;
      bad_nx        = bad_ff;
      unique case (state_ff)
         ST_LOAD: begin
            if (start) begin
               if (count_ff < CNT_W'(MAX_ENTITIES)) begin
                  we       = 1'b1;
                  count_nx = count_ff + 1'b1;
                  if (!req_data.entry.is_rectangle && !err_ff) begin
                     err_nx = 1'b1;
                     bad_nx = count_ff[IDX_W-1:0];
                  end
               end
               count_in = count_nx;
               err_in   = err_nx;
               bad_in   = bad_nx;
               if (req_data.last_entity) begin
                  count_in  = '0;
                  err_in    = 1'b0;
                  i_in      = '0;
                  n_last_in = IDX_W'(count_nx - 1'b1);
                  if (32'(count_nx) > RESULT_LIMIT) begin
                     res_last_in = IDX_W'(RESULT_LIMIT - 1);
                  end else begin
                     res_last_in = IDX_W'(count_nx - 1'b1);
                  end
                  if (err_nx && count_nx >= CNT_W'(2)) begin
                     state_in = ST_ERROR;
                  end else begin
                     state_in = ST_FETCH;
                  end
               end
            end
         end
         ST_FETCH: begin
            rd_addr  = i_ff;
            state_in = ST_LATCH;
         end
         ST_LATCH: begin
            box_i_in = rd_data_ff;
            rd_addr  = '0;
            jd_in    = '0;
            mask_in  = '0;
            hit_in   = 1'b0;
            state_in = ST_ROW;
         end
         ST_ROW: begin
            if (jd_ff != i_ff && pair_hit) begin
               hit_in = 1'b1;
               if (32'(jd_ff) < MASK_BITS) begin
                  mask_in = mask_ff | (MASK_BITS'(1) << jd_ff);
               end
            end
            if (jd_ff == n_last_ff) begin
               state_in = ST_EMIT;
            end else begin
               rd_addr  = jd_ff + 1'b1;
               jd_in    = jd_ff + 1'b1;
            end
         end
         ST_EMIT: begin
            rsp_strobe_in = 1'b1;
            rsp_data_in   = '{entity_index: 6'(i_ff), collided: hit_ff, partner_mask: mask_ff,
                              unsupported_shape: 1'b0, last_result: (i_ff == res_last_ff)};
            if (i_ff == res_last_ff) begin
               state_in = ST_LOAD;
            end else begin
               i_in     = i_ff + 1'b1;
               state_in = ST_FETCH;
            end
         end
         ST_ERROR: begin
            rsp_strobe_in = 1'b1;
            rsp_data_in   = '{entity_index: 6'(bad_ff), collided: 1'b0, partner_mask: '0,
                              unsupported_shape: 1'b1, last_result: 1'b1};
            state_in      = ST_LOAD;
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   assign busy       = (state_ff != ST_LOAD);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_data_ff;

endmodule

// ===== tb/pairwise_box_collision_sweep_core_test.sv =====
// Self-checking testbench for the all-pairs box collision sweep core.
module pairwise_box_collision_sweep_core_test;
   import pbcs_pkg::*;

   localparam int BOX_SLOTS = 32;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int RANDOM_ITEMS = 350;
   localparam logic [1:0] KIND_PLAIN = 2'd0;
   localparam logic [1:0] KIND_ELASTIC = 2'd1;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   logic    busy;
   req_type req_data = '0;
   logic    rsp_strobe;
   rsp_type rsp_data;

   entry_type box_store[BOX_SLOTS];
   int        box_count = 0;
   bit        shape_fault = 1'b0;
   rsp_type   pending_reports[$];

   int  fault_count = 0;
   int  items_sent = 0;
   int  runs_sent = 0;
   int  reports_seen = 0;
   int  hits_seen = 0;
   int  shape_reports = 0;
   int  idle_cycles = 0;
   bit  pacing_quiet = 1'b0;

   pairwise_box_collision_sweep_core #(.MAX_ENTITIES(BOX_SLOTS)) u_dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_data(req_data),
      .rsp_strobe(rsp_strobe),
      .rsp_data(rsp_data)
   );

   always #5 clock = ~clock;

   function automatic bit against(int acc, int vel);
      return (acc < 0 && vel > 0) || (acc > 0 && vel < 0);
   endfunction

   function automatic bit spans_meet(int a0, int al, int b0, int bl);
      int lo;
      int hi;
      lo = (a0 > b0) ? a0 : b0;
      hi = (a0 + al < b0 + bl) ? a0 + al : b0 + bl;
      return hi > lo;
   endfunction

   function automatic bit boxes_clash(entry_type a, entry_type b);
      bit        rest_a;
      bit        rest_b;
      entry_type m;
      if (a.body_kind == KIND_GHOST || b.body_kind == KIND_GHOST) return 1'b0;
      rest_a = (a.body_kind == KIND_FIXED) || (a.vel_x == 0 && a.vel_y == 0);
      rest_b = (b.body_kind == KIND_FIXED) || (b.vel_x == 0 && b.vel_y == 0);
      if (rest_a || rest_b) begin
         m = (rest_b && !rest_a) ? a : b;
         if (against(int'(m.acc_x), int'(m.vel_x)) || against(int'(m.acc_y), int'(m.vel_y)))
            return 1'b0;
      end
      if (a.box_width <= 0 || a.box_height <= 0 || b.box_width <= 0 || b.box_height <= 0)
         return 1'b0;
      return spans_meet(int'(a.pos_x), int'(a.box_width), int'(b.pos_x), int'(b.box_width)) &&
             spans_meet(int'(a.pos_y), int'(a.box_height), int'(b.pos_y), int'(b.box_height));
   endfunction

   // Updates the box store for one accepted beat and queues the reports a sweep produces.
   function automatic void absorb_box(req_type beat);
      int          n;
      int          bad;
      bit          hit[BOX_SLOTS];
      logic [31:0] mask[BOX_SLOTS];
      rsp_type     rep;
      if (box_count < BOX_SLOTS) begin
         box_store[box_count] = beat.entry;
         if (!beat.entry.is_rectangle) shape_fault = 1'b1;
         box_count++;
      end
      if (!beat.last_entity) return;
      n = box_count;
      box_count = 0;
      if (n >= 2 && shape_fault) begin
         bad = 0;
         for (int i = n - 1; i >= 0; i--) begin
            if (!box_store[i].is_rectangle) bad = i;
         end
         shape_fault = 1'b0;
         rep = '0;
         rep.entity_index = 6'(bad);
         rep.unsupported_shape = 1'b1;
         rep.last_result = 1'b1;
         pending_reports.push_back(rep);
         return;
      end
      shape_fault = 1'b0;
      for (int i = 0; i < n; i++) begin
         hit[i] = 1'b0;
         mask[i] = '0;
      end
      for (int i = 0; i < n; i++) begin
         for (int j = i + 1; j < n; j++) begin
            if (boxes_clash(box_store[i], box_store[j])) begin
               hit[i] = 1'b1;
               hit[j] = 1'b1;
               mask[i][j] = 1'b1;
               mask[j][i] = 1'b1;
            end
         end
      end
      for (int i = 0; i < n; i++) begin
         rep = '0;
         rep.entity_index = 6'(i);
         rep.collided = hit[i];
         rep.partner_mask = mask[i];
         rep.last_result = (i + 1 == n);
         pending_reports.push_back(rep);
      end
   endfunction

   function automatic entry_type rect_box(int x, int y, int w, int h, int vx, int vy,
                                          int ax, int ay, logic [1:0] kind);
      entry_type e;
      e.pos_x = 16'(x);
      e.pos_y = 16'(y);
      e.box_width = 16'(w);
      e.box_height = 16'(h);
      e.vel_x = 16'(vx);
      e.vel_y = 16'(vy);
      e.acc_x = 16'(ax);
      e.acc_y = 16'(ay);
      e.body_kind = kind;
      e.is_rectangle = 1'b1;
      return e;
   endfunction

   function automatic int spread(int lim);
      return int'($urandom_range(0, 2 * lim)) - lim;
   endfunction

   function automatic logic [15:0] pick_motion();
      int r;
      r = $urandom_range(0, 99);
      if (r < 40) return 16'd0;
      if (r < 85) return 16'(spread(512));
      return 16'($urandom);
   endfunction

   function automatic logic [15:0] pick_extent();
      int r;
      r = $urandom_range(0, 99);
      if (r < 80) return 16'($urandom_range(1, 12));
      if (r < 88) return 16'(-int'($urandom_range(0, 4)));
      return 16'($urandom);
   endfunction

   // Boxes packed into a small window so that overlaps are common.
   function automatic entry_type shaped_box();
      entry_type e;
      e.pos_x = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'(spread(16));
      e.pos_y = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'(spread(16));
      e.box_width = pick_extent();
      e.box_height = pick_extent();
      e.vel_x = pick_motion();
      e.vel_y = pick_motion();
      e.acc_x = pick_motion();
      e.acc_y = pick_motion();
      e.body_kind = 2'($urandom_range(0, 3));
      e.is_rectangle = ($urandom_range(0, 39) != 0);
      return e;
   endfunction

   function automatic entry_type noise_box();
      entry_type e;
      e.pos_x = 16'($urandom);
      e.pos_y = 16'($urandom);
      e.box_width = 16'($urandom);
      e.box_height = 16'($urandom);
      e.vel_x = 16'($urandom);
      e.vel_y = 16'($urandom);
      e.acc_x = 16'($urandom);
      e.acc_y = 16'($urandom);
      e.body_kind = 2'($urandom);
      e.is_rectangle = 1'($urandom);
      return e;
   endfunction

   function automatic int draw_gap();
      return pacing_quiet ? 0 : int'($urandom_range(0, 10));
   endfunction

   task automatic send_box(input entry_type box, input bit last_flag);
      int gap;
      req_type beat;
      gap = draw_gap();
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      beat.entry = box;
      beat.last_entity = last_flag;
      req_data <= beat;
      start <= 1'b1;
      do @(posedge clock); while (busy);
      absorb_box(beat);
      items_sent++;
      if (last_flag) runs_sent++;
   endtask

   task automatic send_pair(input entry_type a, input entry_type b);
      send_box(a, 1'b0);
      send_box(b, 1'b1);
   endtask

   task automatic wait_drained();
      start <= 1'b0;
      do @(posedge clock); while (pending_reports.size() != 0);
   endtask

   task automatic test_single_box();
      entry_type e;
      send_box(rect_box(3, 4, 5, 6, 256, 0, 0, 0, KIND_PLAIN), 1'b1);
      e = rect_box(-3, -4, 5, 6, 0, 0, 0, 0, KIND_ELASTIC);
      e.is_rectangle = 1'b0;
      send_box(e, 1'b1);
      wait_drained();
   endtask

   task automatic test_pair_rules();
      send_pair(rect_box(0, 0, 10, 10, 256, 0, 0, 0, KIND_PLAIN),
                rect_box(5, 5, 10, 10, -256, 0, 0, 0, KIND_ELASTIC));
      send_pair(rect_box(0, 0, 10, 10, 0, 0, 0, 0, KIND_PLAIN),
                rect_box(10, 0, 10, 10, 0, 0, 0, 0, KIND_PLAIN));
      send_pair(rect_box(0, 0, 0, 10, 0, 0, 0, 0, KIND_PLAIN),
                rect_box(0, 0, 10, 10, 0, 0, 0, 0, KIND_PLAIN));
      send_pair(rect_box(0, 0, 10, 10, 0, 0, 0, 0, KIND_PLAIN),
                rect_box(0, 0, -32768, -5, 0, 0, 0, 0, KIND_PLAIN));
      send_pair(rect_box(0, 0, 10, 10, 0, 0, 0, 0, KIND_GHOST),
                rect_box(2, 2, 10, 10, 0, 0, 0, 0, KIND_PLAIN));
      send_pair(rect_box(0, 0, 10, 10, 256, 256, 0, 0, KIND_FIXED),
                rect_box(2, 2, 10, 10, 256, 0, -1, 0, KIND_PLAIN));
      send_pair(rect_box(0, 0, 10, 10, 0, -256, 0, 5, KIND_ELASTIC),
                rect_box(2, 2, 10, 10, 0, 0, 0, 0, KIND_PLAIN));
      send_pair(rect_box(0, 0, 10, 10, 256, 0, -256, 0, KIND_PLAIN),
                rect_box(2, 2, 10, 10, 0, 256, 0, -256, KIND_ELASTIC));
      send_pair(rect_box(32767, 32767, 32767, 32767, 0, 0, 32767, 32767, KIND_FIXED),
                rect_box(32000, 32000, 32767, 32767, 0, 0, -32768, -32768, KIND_PLAIN));
      send_pair(rect_box(-32768, -32768, 100, 100, -32768, 32767, 32767, -32768, KIND_ELASTIC),
                rect_box(-32700, -32700, 10, 10, 0, 0, 0, 0, KIND_PLAIN));
      wait_drained();
   endtask

   task automatic test_shape_error();
      entry_type e;
      send_box(rect_box(0, 0, 10, 10, 0, 0, 0, 0, KIND_PLAIN), 1'b0);
      e = rect_box(1, 1, 10, 10, 0, 0, 0, 0, KIND_PLAIN);
      e.is_rectangle = 1'b0;
      send_box(e, 1'b0);
      send_box(rect_box(2, 2, 10, 10, 0, 0, 0, 0, KIND_PLAIN), 1'b1);
      wait_drained();
   endtask

   task automatic test_random_runs();
      int n;
      int r;
      int random_items;
      random_items = 0;
      while (random_items < RANDOM_ITEMS) begin
         pacing_quiet = ($urandom_range(0, 3) == 0);
         r = $urandom_range(0, 99);
         if (r < 60) n = $urandom_range(2, 6);
         else if (r < 75) n = 1;
         else if (r < 92) n = $urandom_range(7, 16);
         else n = $urandom_range(17, BOX_SLOTS);
         r = $urandom_range(0, 99);
         for (int i = 0; i < n; i++) begin
            send_box((r < 15) ? noise_box() : shaped_box(), i == n - 1);
         end
         random_items += n;
         if ($urandom_range(0, 9) == 0) wait_drained();
      end
      pacing_quiet = 1'b0;
      wait_drained();
   endtask

   // Boxes past a full store are dropped, even a non-rectangle one carrying the last flag.
   task automatic test_store_full();
      entry_type e;
      for (int i = 0; i < BOX_SLOTS; i++) begin
         e = shaped_box();
         e.is_rectangle = 1'b1;
         send_box(e, 1'b0);
      end
      e = shaped_box();
      e.is_rectangle = 1'b0;
      send_box(e, 1'b0);
      send_box(e, 1'b1);
      wait_drained();
   endtask

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
         fault_count++;
      end
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_strobe) begin
         reports_seen++;
         if (rsp_data.collided === 1'b1) hits_seen++;
         if (rsp_data.unsupported_shape === 1'b1) shape_reports++;
         if (pending_reports.size() == 0) begin
            $error("result beat for entity %0d with none expected", rsp_data.entity_index);
            fault_count++;
         end else begin
            want = pending_reports.pop_front();
            check_field("entity_index", 32'(want.entity_index), 32'(rsp_data.entity_index));
            check_field("collided", 32'(want.collided), 32'(rsp_data.collided));
            check_field("partner_mask", want.partner_mask, rsp_data.partner_mask);
            check_field("unsupported_shape", 32'(want.unsupported_shape),
                        32'(rsp_data.unsupported_shape));
            check_field("last_result", 32'(want.last_result), 32'(rsp_data.last_result));
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles == WATCHDOG_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
         end
      end
   end

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_single_box();
      test_pair_rules();
      test_shape_error();
      test_random_runs();
      test_store_full();
      repeat (40) @(posedge clock);
      $display("Sent %0d boxes in %0d sweeps; checked %0d result beats.",
               items_sent, runs_sent, reports_seen);
      $display("Seen %0d colliding boxes and %0d shape-error reports.",
               hits_seen, shape_reports);
      if (fault_count == 0 && pending_reports.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

// ===== pairwise_box_collision_sweep_core.f =====
design/pbcs_pkg.sv
design/pairwise_box_collision_sweep_core.sv
tb/pairwise_box_collision_sweep_core_test.sv
